[sv/tevq_pkg.sv]
// ----------------------------------------------------------------------------
// tevq_pkg
// Sizes, codes and helper functions of the task and event message queues.
// ----------------------------------------------------------------------------
package tevq_pkg;

  localparam int TASKS      = 4;
  localparam int EVENTS     = 8;
  localparam int DEPTH      = 8;
  localparam int DATA_WIDTH = 16;

  localparam int NQ    = TASKS * EVENTS;
  localparam int SLOTS = NQ * DEPTH;
  localparam int QW    = (NQ > 1) ? $clog2(NQ) : 1;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int SA_W  = $clog2(SLOTS);
  localparam int EV_W  = (EVENTS > 1) ? $clog2(EVENTS) : 1;

  typedef enum logic [1:0] {OP_SEND, OP_RECV, OP_PEEK, OP_LEN} op_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_TASK,
    ST_BAD_EVENT,
    ST_FULL,
    ST_EMPTY
  } status_t;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef struct packed {
    logic            ok;
    logic [EV_W-1:0] idx;
  } ev_t;

  function automatic ptr_t ptr_inc(ptr_t p);
    return (int'(p) == DEPTH - 1) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t ptr_count(ptr_t wp, ptr_t rp);
    if (wp >= rp) begin
      return ptr_t'(wp - rp);
    end
    return ptr_t'(int'(wp) + DEPTH - int'(rp));
  endfunction

  function automatic ev_t ev_decode(logic [7:0] flag);
    ev_t r;
    r = '0;
    for (int i = 0; i < EVENTS; i++) begin
      if (flag == 8'(1 << i)) begin
        r.ok  = 1'b1;
        r.idx = EV_W'(i);
      end
    end
    return r;
  endfunction

endpackage

[sv/tevq_ram.sv]
// ----------------------------------------------------------------------------
// tevq_ram
// Simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module tevq_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 256,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/task_event_message_queues.sv]
// ----------------------------------------------------------------------------
// task_event_message_queues
// One circular FIFO of message words for every task and event pair.
// ----------------------------------------------------------------------------
// Each item selects a queue by task number and one-hot event bit and sends,
// receives, peeks or queries the length; exactly one result item follows.
// Queue pointers live in a pointer RAM and the words in a slot RAM, both
// with a registered read. An item with a bad task or event goes from S_IDLE
// to S_LOAD; a send, a length query or a failed receive or peek passes S_PTR,
// and a successful receive or peek also S_SLOT, as the slot address comes
// from the pointer RAM read. The next item is taken as soon as the result
// has moved into the output register, even while it still waits there.
// Each queue holds at most DEPTH-1 words. No clearing pass follows reset.
// ----------------------------------------------------------------------------
module task_event_message_queues import tevq_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // task_id [7:0], event_sel [15:8], data_in [31:16]
  input  logic [1:0]  s_tuser,  // op [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,  // data_out [15:0], queue_length [18:16],
                                // queue_error [19], zero [23:20]
  output logic [3:0]  m_tuser   // status [2:0], data_valid [3]
);

  typedef enum logic [1:0] {S_IDLE, S_PTR, S_SLOT, S_LOAD} state_t;

  typedef struct packed {
    status_t               status;
    logic [DATA_WIDTH-1:0] dout;
    logic                  valid;
    ptr_t                  qlen;
  } res_t;

  state_t                state;
  op_t                   op;
  logic [QW-1:0]         q;
  logic [DATA_WIDTH-1:0] wdata;
  logic                  ptr_ok;
  res_t                  res;
  res_t                  out_res;
  logic                  out_err;
  logic                  sticky_error;
  logic [NQ-1:0]         ptr_valid;

  logic [7:0]            in_task;
  logic [7:0]            in_flag;
  logic [15:0]           in_data;
  ev_t                   ev;
  logic                  task_ok;
  logic [QW-1:0]         q_in;
  logic                  s_accept;
  logic                  out_load;

  logic [2*PTR_W-1:0]    ptr_rdata;
  logic [2*PTR_W-1:0]    ptr_wdata;
  logic                  ptr_we;
  ptr_t                  wp;
  ptr_t                  rp;
  ptr_t                  cnt;
  logic                  full;
  logic                  empty;

  logic                  slot_we;
  logic [SA_W-1:0]       slot_waddr;
  logic [SA_W-1:0]       slot_raddr;
  logic [DATA_WIDTH-1:0] slot_rdata;

  assign in_task  = s_tdata[7:0];
  assign in_flag  = s_tdata[15:8];
  assign in_data  = s_tdata[31:16];
  assign ev       = ev_decode(in_flag);
  assign task_ok  = int'(in_task) < TASKS;
  assign q_in     = QW'(int'(in_task) * EVENTS + int'(ev.idx));
  assign s_tready = (state == S_IDLE);
  assign s_accept = s_tvalid && s_tready;
  assign out_load = (state == S_LOAD) && (!m_tvalid || m_tready);

  assign wp    = ptr_ok ? ptr_rdata[2*PTR_W-1:PTR_W] : '0;
  assign rp    = ptr_ok ? ptr_rdata[PTR_W-1:0] : '0;
  assign cnt   = ptr_count(wp, rp);
  assign full  = (ptr_inc(wp) == rp);
  assign empty = (wp == rp);

  assign ptr_we    = (state == S_PTR) &&
                     (((op == OP_SEND) && !full) || ((op == OP_RECV) && !empty));
  assign ptr_wdata = (op == OP_SEND) ? {ptr_inc(wp), rp} : {wp, ptr_inc(rp)};

  assign slot_we    = (state == S_PTR) && (op == OP_SEND) && !full;
  assign slot_waddr = SA_W'(int'(q) * DEPTH + int'(wp));
  assign slot_raddr = SA_W'(int'(q) * DEPTH + int'(rp));

  tevq_ram #(.WIDTH(2 * PTR_W), .DEPTH(NQ)) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (q),
    .wdata (ptr_wdata),
    .raddr (q_in),
    .rdata (ptr_rdata)
  );

  tevq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (wdata),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      sticky_error <= 1'b0;
      m_tvalid     <= 1'b0;
      ptr_valid    <= '0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op        <= op_t'(s_tuser);
            q         <= q_in;
            wdata     <= DATA_WIDTH'(in_data);
            ptr_ok    <= (task_ok && ev.ok) ? ptr_valid[q_in] : 1'b0;
            res.dout  <= '0;
            res.valid <= 1'b0;
            res.qlen  <= '0;
            if (!task_ok) begin
              res.status <= ST_BAD_TASK;
              state      <= S_LOAD;
            end else if (!ev.ok) begin
              res.status <= ST_BAD_EVENT;
              state      <= S_LOAD;
            end else begin
              res.status <= ST_OK;
              state      <= S_PTR;
            end
          end
        end
        S_PTR: begin
          if (ptr_we) begin
            ptr_valid[q] <= 1'b1;
          end
          case (op)
            OP_SEND: begin
              state <= S_LOAD;
              if (full) begin
                res.status   <= ST_FULL;
                res.qlen     <= cnt;
                sticky_error <= 1'b1;
              end else begin
                res.qlen <= ptr_t'(cnt + 1'b1);
              end
            end
            OP_RECV, OP_PEEK: begin
              if (empty) begin
                res.status <= ST_EMPTY;
                res.qlen   <= cnt;
                state      <= S_LOAD;
              end else begin
                res.qlen <= (op == OP_RECV) ? ptr_t'(cnt - 1'b1) : cnt;
                state    <= S_SLOT;
              end
            end
            default: begin
              res.qlen <= cnt;
              state    <= S_LOAD;
            end
          endcase
        end
        S_SLOT: begin
          res.dout  <= slot_rdata;
          res.valid <= 1'b1;
          state     <= S_LOAD;
        end
        S_LOAD: begin
          if (out_load) begin
            out_res <= res;
            out_err <= sticky_error;
            state   <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {4'b0000, out_err, 3'(out_res.qlen), 16'(out_res.dout)};
  assign m_tuser = {out_res.valid, out_res.status};

  a_slot_write_in_ptr: assert property (@(posedge clk) disable iff (rst)
    slot_we |-> (state == S_PTR) && (op == OP_SEND))
    else $error("slot write outside a send");

  a_no_ptr_overlap: assert property (@(posedge clk) disable iff (rst)
    ptr_we |-> !s_accept)
    else $error("pointer write overlaps a pointer read");

  a_error_no_data: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser[2:0] != ST_OK) |-> !m_tuser[3])
    else $error("failed operation returned data");

  a_sticky_holds: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> !$fell(sticky_error))
    else $error("sticky error cleared");

endmodule
